FILE: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge out of reset
`define QST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition never seen out of reset
`define QST_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/qst_pkg.sv
// ----------------------------------------------------------------------------
// qst_pkg
// shared types and constants of the quaternion to scaled transform block
// ----------------------------------------------------------------------------
`default_nettype none
package qst_pkg;

  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int QUAT_W     = 16;
  localparam int ENTRY_W    = 32;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;
  localparam int N_W        = 33;
  localparam int NUM_W      = 35;
  localparam int N_LANES    = 9;
  localparam int FIFO_DEPTH = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_Y = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                row_index;
    logic                      last_row;
    logic signed [ENTRY_W-1:0] entry0;
    logic signed [ENTRY_W-1:0] entry1;
    logic signed [ENTRY_W-1:0] entry2;
    logic signed [ENTRY_W-1:0] entry3;
  } out_item_t;

  // one classified request: norm and the nine signed numerators
  typedef struct packed {
    logic [N_W-1:0]                  n;
    logic [N_LANES-1:0][NUM_W-1:0]   num;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

FILE: hdl/quaternion_to_scaled_transform.sv
// ----------------------------------------------------------------------------
// quaternion_to_scaled_transform
// quaternion in, zoomed and panned 4x4 transform out as four rows
// ----------------------------------------------------------------------------
// path: product register, request queue, the radix-2 divider lanes of the back
//   with one quotient bit a cycle per entry, zoom register, then the rows;
//   quaternions queue while the back works, and it takes one at its last row
// the four rows leave on consecutive cycles with out_valid, they cannot be stalled
// reset (synchronous, rst_n low): queue and sequencer empty, scale 1.0, pans 0
`default_nettype none
module quaternion_to_scaled_transform #(
  parameter int OUT_FRAC_BITS = qst_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            start,
  input  wire qst_pkg::in_item_t               in_data,
  output logic                                 busy,
  // result rows
  output logic                                 out_valid,
  output qst_pkg::out_item_t                   out_data,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [qst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [qst_pkg::CFG_W-1:0]       cfg_wdata
);

  // configuration registers
  logic [qst_pkg::SCALE_W-1:0] scale_r;
  logic [qst_pkg::ENTRY_W-1:0] pan_x_r, pan_y_r;

  // front to queue, queue to back
  logic                push, pop;
  qst_pkg::work_t      wr_work, rd_work;
  qst_pkg::fifo_stat_t fifo_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= qst_pkg::SCALE_RESET;
      pan_x_r <= '0;
      pan_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qst_pkg::REG_SCALE: scale_r <= cfg_wdata[qst_pkg::SCALE_W-1:0];
        qst_pkg::REG_PAN_X: pan_x_r <= cfg_wdata;
        qst_pkg::REG_PAN_Y: pan_y_r <= cfg_wdata;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // products and numerators, one request a cycle while busy is low (queue not full)
  qst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .fifo_stat (fifo_stat),
    .push      (push),
    .work      (wr_work)
  );

  // decouples the front from the divider lanes
  qst_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_work),
    .pop     (pop),
    .rd_data (rd_work),
    .stat    (fifo_stat)
  );

  // division, zoom, saturation and row output
  qst_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .work      (rd_work),
    .pop       (pop),
    .scale     (scale_r),
    .pan_x     (pan_x_r),
    .pan_y     (pan_y_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: hdl/qst_front.sv
// ----------------------------------------------------------------------------
// qst_front
// accepts quaternions, forms the products, norm and rotation numerators
// ----------------------------------------------------------------------------
`default_nettype none
module qst_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire qst_pkg::in_item_t  in_data,
  output logic                    busy,
  input  wire qst_pkg::fifo_stat_t fifo_stat,
  output logic                    push,
  output qst_pkg::work_t          work
);

  localparam int PW = 2 * qst_pkg::QUAT_W;
  localparam int NW = qst_pkg::NUM_W;

  logic s1_v_r, s1_v_nxt;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic accept;

  logic signed [NW-1:0] sxx, syy, szz, sww, sxy, sxz, syz, swx, swy, swz, n;

  assign push   = s1_v_r && !fifo_stat.full;
  assign busy   = s1_v_r && fifo_stat.full;
  assign accept = start && !busy;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xx_r <= in_data.quat_x * in_data.quat_x;
      yy_r <= in_data.quat_y * in_data.quat_y;
      zz_r <= in_data.quat_z * in_data.quat_z;
      ww_r <= in_data.quat_w * in_data.quat_w;
      xy_r <= in_data.quat_x * in_data.quat_y;
      xz_r <= in_data.quat_x * in_data.quat_z;
      yz_r <= in_data.quat_y * in_data.quat_z;
      wx_r <= in_data.quat_w * in_data.quat_x;
      wy_r <= in_data.quat_w * in_data.quat_y;
      wz_r <= in_data.quat_w * in_data.quat_z;
    end
  end

  always_comb begin
    sxx = NW'(xx_r);
    syy = NW'(yy_r);
    szz = NW'(zz_r);
    sww = NW'(ww_r);
    sxy = NW'(xy_r);
    sxz = NW'(xz_r);
    syz = NW'(yz_r);
    swx = NW'(wx_r);
    swy = NW'(wy_r);
    swz = NW'(wz_r);
    n   = sxx + syy + szz + sww;
    work.n      = n[qst_pkg::N_W-1:0];
    work.num[0] = n - ((syy + szz) <<< 1);
    work.num[1] = (sxy - swz) <<< 1;
    work.num[2] = (sxz + swy) <<< 1;
    work.num[3] = (sxy + swz) <<< 1;
    work.num[4] = n - ((sxx + szz) <<< 1);
    work.num[5] = (syz - swx) <<< 1;
    work.num[6] = (sxz - swy) <<< 1;
    work.num[7] = (syz + swx) <<< 1;
    work.num[8] = n - ((sxx + syy) <<< 1);
  end

endmodule
`default_nettype wire

FILE: hdl/qst_fifo.sv
// ----------------------------------------------------------------------------
// qst_fifo
// short request queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none
module qst_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire qst_pkg::work_t      wr_data,
  input  wire logic                pop,
  output qst_pkg::work_t           rd_data,
  output qst_pkg::fifo_stat_t      stat
);

  localparam int D  = qst_pkg::FIFO_DEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  qst_pkg::work_t mem_r [D];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(D));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/qst_back.sv
// ----------------------------------------------------------------------------
// qst_back
// nine radix-2 divider lanes, zoom and saturation, row sequencer
// ----------------------------------------------------------------------------
`default_nettype none
module qst_back #(
  parameter int OUT_FRAC_BITS = qst_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire qst_pkg::fifo_stat_t           fifo_stat,
  input  wire qst_pkg::work_t                work,
  output logic                               pop,
  input  wire logic [qst_pkg::SCALE_W-1:0]   scale,
  input  wire logic [qst_pkg::ENTRY_W-1:0]   pan_x,
  input  wire logic [qst_pkg::ENTRY_W-1:0]   pan_y,
  output logic                               out_valid,
  output qst_pkg::out_item_t                 out_data
);

  localparam int L     = qst_pkg::N_LANES;
  localparam int NW    = qst_pkg::NUM_W;
  localparam int MW    = NW - 1;
  localparam int QW    = OUT_FRAC_BITS + 1;
  localparam int DW    = MW + OUT_FRAC_BITS + 1;
  localparam int RW    = DW - QW;
  localparam int CNTW  = $clog2(QW + 1);
  localparam int EW    = qst_pkg::ENTRY_W;
  localparam int PRW   = QW + qst_pkg::SCALE_W;
  localparam int ZW    = PRW - qst_pkg::SCALE_FRAC;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ZOOM = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [EW-1:0] ONE_OUT = EW'(64'd1 << OUT_FRAC_BITS);
  localparam logic [63:0]   POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0]   NEG_MAX = 64'h0000_0000_8000_0000;

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [1:0]      row_r, row_nxt;
  logic [qst_pkg::N_W-1:0] d_r;
  logic            zero_r;
  logic [RW-1:0]   rem_r [L];
  logic [QW-1:0]   low_r [L];
  logic [QW-1:0]   q_r   [L];
  logic            neg_r [L];
  logic [EW-1:0]   ent_r [L];

  logic [RW-1:0]   rem_ld [L];
  logic [QW-1:0]   low_ld [L];
  logic            neg_ld [L];
  logic [RW-1:0]   rem_st [L];
  logic [QW-1:0]   q_st   [L];
  logic [EW-1:0]   ent_z  [L];
  logic            load;

  // next item is taken when idle or while the last row goes out
  assign load = !fifo_stat.empty &&
                ((state_r == S_IDLE) || ((state_r == S_EMIT) && (row_r == 2'd3)));
  assign pop  = load;

  always_comb begin
    logic signed [NW-1:0] nv;
    logic [MW-1:0]        mag;
    logic [DW-1:0]        dd;
    logic [RW:0]          t;
    logic [RW:0]          dz;
    logic [QW-1:0]        r;
    logic [PRW-1:0]       prod;
    logic [ZW-1:0]        zm;
    logic [63:0]          z64;
    for (int k = 0; k < L; k++) begin
      nv = $signed(work.num[k]);
      neg_ld[k] = nv[NW-1];
      mag = nv[NW-1] ? MW'(-nv) : MW'(nv);
      dd = (DW'(mag) << OUT_FRAC_BITS) + DW'(work.n >> 1);
      rem_ld[k] = dd[DW-1:QW];
      low_ld[k] = dd[QW-1:0];

      t  = {rem_r[k], low_r[k][QW-1]};
      dz = (RW + 1)'(d_r);
      if (t >= dz) begin
        rem_st[k] = RW'(t - dz);
        q_st[k]   = {q_r[k][QW-2:0], 1'b1};
      end else begin
        rem_st[k] = t[RW-1:0];
        q_st[k]   = {q_r[k][QW-2:0], 1'b0};
      end

      // zero norm gives identity
      if (zero_r) begin
        r = ((k % 4) == 0) ? QW'(64'd1 << OUT_FRAC_BITS) : '0;
      end else begin
        r = q_r[k];
      end
      prod = PRW'(r) * PRW'(scale);
      prod = prod + PRW'(64'd1 << (qst_pkg::SCALE_FRAC - 1));
      zm   = prod[PRW-1:qst_pkg::SCALE_FRAC];
      z64  = 64'(zm);
      if (!neg_r[k] || zero_r) begin
        ent_z[k] = (z64 > POS_MAX) ? POS_MAX[EW-1:0] : z64[EW-1:0];
      end else begin
        ent_z[k] = (z64 > NEG_MAX) ? NEG_MAX[EW-1:0] : EW'(-z64);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    case (state_r)
      S_IDLE: begin
        if (load) begin
          state_nxt = S_DIV;
          cnt_nxt   = CNTW'(QW);
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          state_nxt = S_ZOOM;
        end
      end
      S_ZOOM: begin
        state_nxt = S_EMIT;
        row_nxt   = 2'd0;
      end
      S_EMIT: begin
        row_nxt = row_r + 1'b1;
        if (row_r == 2'd3) begin
          if (load) begin
            state_nxt = S_DIV;
            cnt_nxt   = CNTW'(QW);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r    <= work.n;
      zero_r <= (work.n == '0);
    end
    for (int k = 0; k < L; k++) begin
      if (load) begin
        rem_r[k] <= rem_ld[k];
        low_r[k] <= low_ld[k];
        neg_r[k] <= neg_ld[k];
        q_r[k]   <= '0;
      end else if (state_r == S_DIV) begin
        rem_r[k] <= rem_st[k];
        low_r[k] <= {low_r[k][QW-2:0], 1'b0};
        q_r[k]   <= q_st[k];
      end
      if (state_r == S_ZOOM) begin
        ent_r[k] <= ent_z[k];
      end
    end
  end

  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    out_data.row_index = row_r;
    out_data.last_row  = (row_r == 2'd3);
    case (row_r)
      2'd0: begin
        out_data.entry0 = ent_r[0];
        out_data.entry1 = ent_r[1];
        out_data.entry2 = ent_r[2];
        out_data.entry3 = pan_x;
      end
      2'd1: begin
        out_data.entry0 = ent_r[3];
        out_data.entry1 = ent_r[4];
        out_data.entry2 = ent_r[5];
        out_data.entry3 = pan_y;
      end
      2'd2: begin
        out_data.entry0 = ent_r[6];
        out_data.entry1 = ent_r[7];
        out_data.entry2 = ent_r[8];
        out_data.entry3 = '0;
      end
      default: begin
        out_data.entry0 = '0;
        out_data.entry1 = '0;
        out_data.entry2 = '0;
        out_data.entry3 = ONE_OUT;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/qst_checker.sv
// ----------------------------------------------------------------------------
// qst_checker
// port-level checks on the row sequence and fixed entries of the transform block
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module qst_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire qst_pkg::out_item_t out_data
);

  `QST_ASSERT(a_last_is_row3, clk, rst_n, out_valid |-> (out_data.last_row == (out_data.row_index == 2'd3)), "last_row mismatch")
  `QST_ASSERT(a_rows_run, clk, rst_n, (out_valid && !out_data.last_row) |=> (out_valid && out_data.row_index == $past(out_data.row_index) + 2'd1), "row sequence broken")
  `QST_ASSERT(a_row3_const, clk, rst_n, (out_valid && out_data.row_index == 2'd3) |-> (out_data.entry0 == 0 && out_data.entry1 == 0 && out_data.entry2 == 0), "bottom row not zero")
  `QST_ASSERT_NEVER(a_row2_pan, clk, rst_n, out_valid && out_data.row_index == 2'd2 && out_data.entry3 != 0, "entry [2][3] not zero")

endmodule

bind quaternion_to_scaled_transform qst_checker u_qst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
